@@ design/ssd_pkg.sv @@
// ----------------------------------------------------------------------------
// ssd_pkg
// shared types and constants of the smbios structure deframer
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam logic [7:0]  END_TYPE   = 8'd127;
    localparam logic [7:0]  MIN_LENGTH = 8'd4;
    localparam logic [7:0]  STRING_MAX = 8'hFF;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

    typedef enum logic [2:0] {
        KIND_TYPE       = 3'd0,
        KIND_LENGTH     = 3'd1,
        KIND_HANDLE     = 3'd2,
        KIND_FORMATTED  = 3'd3,
        KIND_STR_CHAR   = 3'd4,
        KIND_STR_END    = 3'd5,
        KIND_STRUCT_END = 3'd6,
        KIND_IGNORED    = 3'd7
    } t_byte_kind;

    typedef enum logic [1:0] {
        ERR_NONE         = 2'd0,
        ERR_TRUNCATED    = 2'd1,
        ERR_SHORT_LENGTH = 2'd2
    } t_parse_error;

    typedef struct packed {
        logic [7:0] table_byte;
        logic       table_start;
    } t_in_item;

    // item as held between front and back, with its zero flag already worked out
    typedef struct packed {
        logic [7:0] table_byte;
        logic       table_start;
        logic       is_zero;
    } t_front_item;

    typedef struct packed {
        t_byte_kind   byte_kind;
        logic [7:0]   struct_type;
        logic [7:0]   struct_length;
        logic [15:0]  struct_handle;
        logic [7:0]   field_offset;
        logic [7:0]   string_number;
        logic [7:0]   data_byte;
        logic [15:0]  structure_count;
        logic         table_done;
        t_parse_error parse_error;
    } t_result;

    // queue status flags: empty for the reading side, full for the writing side
    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

endpackage

@@ design/ssd_front.sv @@
// ----------------------------------------------------------------------------
// ssd_front
// input side: two-entry queue of table bytes, each tagged with a zero flag
// ----------------------------------------------------------------------------
module ssd_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ssd_pkg::t_in_item     i_item,
    input  logic                  i_pop,
    output ssd_pkg::t_queue_status o_status,
    output ssd_pkg::t_front_item  o_item
);
    import ssd_pkg::*;

    t_front_item r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        n_wr_ptr;
    logic        n_rd_ptr;
    logic [1:0]  n_count;
    logic        do_push;
    logic        do_pop;

    assign o_status.empty = (r_count == 2'd0);
    assign o_status.full  = (r_count == 2'd2);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = do_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr].table_byte  <= i_item.table_byte;
            r_mem[r_wr_ptr].table_start <= i_item.table_start;
            r_mem[r_wr_ptr].is_zero     <= (i_item.table_byte == 8'd0);
        end
    end

endmodule

@@ design/ssd_out_queue.sv @@
// ----------------------------------------------------------------------------
// ssd_out_queue
// two-entry result queue between the parser and the result port
// ----------------------------------------------------------------------------
module ssd_out_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  ssd_pkg::t_result       i_result,
    input  logic                   i_pop,
    output ssd_pkg::t_queue_status o_status,
    output ssd_pkg::t_result       o_result
);
    import ssd_pkg::*;

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       do_push;
    logic       do_pop;

    assign o_status.empty = (r_count == 2'd0);
    assign o_status.full  = (r_count == 2'd2);
    assign do_push  = i_push && !o_status.full;
    assign do_pop   = i_pop && !o_status.empty;
    assign o_result = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

endmodule

@@ design/ssd_parser.sv @@
// ----------------------------------------------------------------------------
// ssd_parser
// back end: structure phases; barring a stall, one table byte classified per cycle
// ----------------------------------------------------------------------------
module ssd_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [15:0]           i_cfg_data,
    input  ssd_pkg::t_queue_status i_in_status,
    input  ssd_pkg::t_front_item  i_item,
    output logic                  o_in_pop,
    input  ssd_pkg::t_queue_status i_out_status,
    output logic                  o_out_push,
    output ssd_pkg::t_result      o_result
);
    import ssd_pkg::*;

    typedef enum logic [2:0] {
        PH_TYPE     = 3'd0,
        PH_LEN      = 3'd1,
        PH_HLO      = 3'd2,
        PH_HHI      = 3'd3,
        PH_FMT      = 3'd4,
        PH_SFIRST   = 3'd5,
        PH_INSTR    = 3'd6,
        PH_SBETWEEN = 3'd7
    } t_phase;

    logic [15:0] r_table_size;
    logic [15:0] r_pos;
    t_phase      r_phase;
    logic [7:0]  r_cur_type;
    logic [7:0]  r_cur_length;
    logic [15:0] r_cur_handle;
    logic [7:0]  r_area_offset;
    logic [7:0]  r_string_idx;
    logic [15:0] r_struct_idx;
    logic        r_ended;

    logic [15:0] n_pos;
    t_phase      n_phase;
    logic [7:0]  n_cur_type;
    logic [7:0]  n_cur_length;
    logic [15:0] n_cur_handle;
    logic [7:0]  n_area_offset;
    logic [7:0]  n_string_idx;
    logic [15:0] n_struct_idx;
    logic        n_ended;

    // state as seen by this byte, after a possible restart
    logic [15:0] e_pos;
    t_phase      e_phase;
    logic [7:0]  e_cur_type;
    logic [7:0]  e_cur_length;
    logic [15:0] e_cur_handle;
    logic [7:0]  e_area_offset;
    logic [7:0]  e_string_idx;
    logic [15:0] e_struct_idx;
    logic        e_ended;

    logic         fire;
    logic         consumed;
    logic [7:0]   b;
    t_byte_kind   kind;
    logic [7:0]   fo;
    logic [7:0]   sn;
    t_parse_error err;

    assign fire       = !i_in_status.empty && !i_out_status.full;
    assign o_in_pop   = fire;
    assign o_out_push = fire;
    assign b          = i_item.table_byte;

    always_comb begin
        if (i_item.table_start) begin
            e_pos         = 16'd0;
            e_phase       = PH_TYPE;
            e_cur_type    = 8'd0;
            e_cur_length  = 8'd0;
            e_cur_handle  = 16'd0;
            e_area_offset = 8'd0;
            e_string_idx  = 8'd0;
            e_struct_idx  = 16'd0;
            e_ended       = 1'b0;
        end else begin
            e_pos         = r_pos;
            e_phase       = r_phase;
            e_cur_type    = r_cur_type;
            e_cur_length  = r_cur_length;
            e_cur_handle  = r_cur_handle;
            e_area_offset = r_area_offset;
            e_string_idx  = r_string_idx;
            e_struct_idx  = r_struct_idx;
            e_ended       = r_ended;
        end

        n_pos         = e_pos;
        n_phase       = e_phase;
        n_cur_type    = e_cur_type;
        n_cur_length  = e_cur_length;
        n_cur_handle  = e_cur_handle;
        n_area_offset = e_area_offset;
        n_string_idx  = e_string_idx;
        n_struct_idx  = e_struct_idx;
        n_ended       = e_ended;

        kind     = KIND_IGNORED;
        fo       = 8'd0;
        sn       = 8'd0;
        err      = ERR_NONE;
        consumed = 1'b0;

        if (!e_ended && (e_pos >= r_table_size)) begin
            n_ended = 1'b1;
        end

        if (!n_ended) begin
            consumed = 1'b1;
            case (e_phase)
                PH_TYPE: begin
                    // fewer than five bytes left cannot hold a structure
                    if (({1'b0, e_pos} + 17'd4) >= {1'b0, r_table_size}) begin
                        n_ended  = 1'b1;
                        consumed = 1'b0;
                    end else begin
                        kind          = KIND_TYPE;
                        n_cur_type    = b;
                        n_cur_length  = 8'd0;
                        n_cur_handle  = 16'd0;
                        n_string_idx  = 8'd0;
                        n_area_offset = 8'd1;
                        n_phase       = PH_LEN;
                    end
                end
                PH_LEN: begin
                    kind         = KIND_LENGTH;
                    fo           = 8'd1;
                    n_cur_length = b;
                    if (b < MIN_LENGTH) begin
                        err     = ERR_SHORT_LENGTH;
                        n_ended = 1'b1;
                    end else if (({1'b0, e_pos} + {9'd0, b}) >
                                 ({1'b0, r_table_size} + 17'd1)) begin
                        err     = ERR_TRUNCATED;
                        n_ended = 1'b1;
                    end else begin
                        n_area_offset = 8'd2;
                        n_phase       = PH_HLO;
                    end
                end
                PH_HLO: begin
                    kind          = KIND_HANDLE;
                    fo            = 8'd2;
                    n_cur_handle  = {8'd0, b};
                    n_area_offset = 8'd3;
                    n_phase       = PH_HHI;
                end
                PH_HHI: begin
                    kind          = KIND_HANDLE;
                    fo            = 8'd3;
                    n_cur_handle  = {b, e_cur_handle[7:0]};
                    n_area_offset = 8'd4;
                    n_phase       = (e_cur_length > MIN_LENGTH) ? PH_FMT : PH_SFIRST;
                end
                PH_FMT: begin
                    kind          = KIND_FORMATTED;
                    fo            = e_area_offset;
                    n_area_offset = e_area_offset + 8'd1;
                    if (n_area_offset >= e_cur_length) begin
                        n_phase = PH_SFIRST;
                    end
                end
                PH_SFIRST: begin
                    // zero straight after the area: empty string set
                    if (i_item.is_zero) begin
                        kind    = KIND_STR_END;
                        n_phase = PH_SBETWEEN;
                    end else begin
                        kind         = KIND_STR_CHAR;
                        n_string_idx = 8'd1;
                        sn           = 8'd1;
                        n_phase      = PH_INSTR;
                    end
                end
                PH_INSTR: begin
                    sn = e_string_idx;
                    if (i_item.is_zero) begin
                        kind    = KIND_STR_END;
                        n_phase = PH_SBETWEEN;
                    end else begin
                        kind = KIND_STR_CHAR;
                    end
                end
                PH_SBETWEEN: begin
                    if (i_item.is_zero) begin
                        kind = KIND_STRUCT_END;
                        if (e_cur_type == END_TYPE) begin
                            n_ended = 1'b1;
                        end
                        if (e_struct_idx != COUNT_MAX) begin
                            n_struct_idx = e_struct_idx + 16'd1;
                        end
                        n_phase = PH_TYPE;
                    end else begin
                        if (e_string_idx != STRING_MAX) begin
                            n_string_idx = e_string_idx + 8'd1;
                        end
                        kind    = KIND_STR_CHAR;
                        sn      = n_string_idx;
                        n_phase = PH_INSTR;
                    end
                end
                default: begin
                    n_phase = PH_TYPE;
                end
            endcase
            if (consumed) begin
                n_pos = e_pos + 16'd1;
                if (n_pos >= r_table_size) begin
                    n_ended = 1'b1;
                end
            end
        end

        o_result.byte_kind       = kind;
        o_result.struct_type     = n_cur_type;
        o_result.struct_length   = n_cur_length;
        o_result.struct_handle   = n_cur_handle;
        o_result.field_offset    = fo;
        o_result.string_number   = sn;
        o_result.data_byte       = b;
        // the index only moves on a structure end, so the old value serves every kind
        o_result.structure_count = e_struct_idx;
        o_result.table_done      = n_ended;
        o_result.parse_error     = err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size  <= 16'd0;
            r_pos         <= 16'd0;
            r_phase       <= PH_TYPE;
            r_cur_type    <= 8'd0;
            r_cur_length  <= 8'd0;
            r_cur_handle  <= 16'd0;
            r_area_offset <= 8'd0;
            r_string_idx  <= 8'd0;
            r_struct_idx  <= 16'd0;
            r_ended       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_table_size <= i_cfg_data;
            end
            if (fire) begin
                r_pos         <= n_pos;
                r_phase       <= n_phase;
                r_cur_type    <= n_cur_type;
                r_cur_length  <= n_cur_length;
                r_cur_handle  <= n_cur_handle;
                r_area_offset <= n_area_offset;
                r_string_idx  <= n_string_idx;
                r_struct_idx  <= n_struct_idx;
                r_ended       <= n_ended;
            end
        end
    end

    a_ended_ignores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_ended && !i_item.table_start |-> o_result.byte_kind == KIND_IGNORED)
        else $error("byte after table end not ignored");

    a_error_on_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && o_result.parse_error != ERR_NONE |->
            o_result.byte_kind == KIND_LENGTH && o_result.table_done)
        else $error("parse error outside a length byte");

    a_end_to_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && o_result.byte_kind == KIND_STRUCT_END |=> r_phase == PH_TYPE)
        else $error("structure end did not return to type phase");

    a_type_to_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && o_result.byte_kind == KIND_TYPE |=> r_phase == PH_LEN && !r_ended)
        else $error("type byte not followed by length phase");

endmodule

@@ design/smbios_structure_deframer.sv @@
// ----------------------------------------------------------------------------
// smbios_structure_deframer
// labels each byte of a raw structure table with its role in the structure
// ----------------------------------------------------------------------------
//  channel   | handshake              | payload
//  ----------+------------------------+----------------------------------
//  input     | push / full            | i_item   (table_byte, table_start)
//  result    | pop / empty            | o_result (byte_kind ... parse_error)
//  config    | i_cfg_valid/o_cfg_ready| i_cfg_data (table_size)
//
//  one byte per clock sustained while the result side keeps popping; a request
//  enters a two-entry input queue, is classified combinationally by the parser
//  and lands in a two-entry result queue, so empty drops once that queue registers it
//  synchronous active-low reset clears the queues, the parse state and table_size
//  a stalled result side fills the result queue, then the input queue, then full rises
//  config is always ready
// ----------------------------------------------------------------------------
module smbios_structure_deframer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  ssd_pkg::t_in_item i_item,
    output logic              empty,
    input  logic              pop,
    output ssd_pkg::t_result  o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [15:0]       i_cfg_data
);
    import ssd_pkg::*;

    t_queue_status in_status;
    t_queue_status out_status;
    t_front_item   front_item;
    t_result       parsed;
    logic          in_pop;
    logic          out_push;

    assign full        = in_status.full;
    assign empty       = out_status.empty;
    assign o_cfg_ready = 1'b1;

    ssd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_item),
        .i_pop    (in_pop),
        .o_status (in_status),
        .o_item   (front_item)
    );

    ssd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_in_status  (in_status),
        .i_item       (front_item),
        .o_in_pop     (in_pop),
        .i_out_status (out_status),
        .o_out_push   (out_push),
        .o_result     (parsed)
    );

    ssd_out_queue u_out_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (out_push),
        .i_result (parsed),
        .i_pop    (pop),
        .o_status (out_status),
        .o_result (o_result)
    );

endmodule
